>>> hdl/trimmed_mean_2x2_downsample_defines.svh
// ----------------------------------------------------------------------------
// trimmed_mean_2x2_downsample_defines
// assertion macros used by the checker file tmd_check
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_2X2_DOWNSAMPLE_DEFINES_SVH
`define TRIMMED_MEAN_2X2_DOWNSAMPLE_DEFINES_SVH

// same-cycle implication under active-low reset
`define TMD_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under active-low reset
`define TMD_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tmd_pkg.sv
// ----------------------------------------------------------------------------
// tmd_pkg
// shared types and constants of the 2x2 trimmed-mean downsampler
// ----------------------------------------------------------------------------
package tmd_pkg;

  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;
  localparam int CFG_W    = 12;
  localparam logic [CFG_W-1:0] WIDTH_RST = 12'd640;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PIX_W-1:0]  pix_t;

  // one 2x2 block ready for the lanes
  typedef struct packed {
    logic valid;
    pix_t above_even;
    pix_t above_odd;
    pix_t held;
    pix_t pix;
  } blk_t;

endpackage

>>> hdl/tmd_pix_if.sv
// ----------------------------------------------------------------------------
// tmd_pix_if
// input pixel channel
// ----------------------------------------------------------------------------
interface tmd_pix_if;
  logic          valid;
  logic          ready;
  logic          start_of_frame;
  tmd_pkg::chan_t chan0;
  tmd_pkg::chan_t chan1;
  tmd_pkg::chan_t chan2;

  modport source (output valid, start_of_frame, chan0, chan1, chan2, input ready);
  modport sink   (input valid, start_of_frame, chan0, chan1, chan2, output ready);
endinterface

>>> hdl/tmd_res_if.sv
// ----------------------------------------------------------------------------
// tmd_res_if
// downsampled result channel
// ----------------------------------------------------------------------------
interface tmd_res_if;
  logic          valid;
  logic          ready;
  tmd_pkg::chan_t out_first;
  tmd_pkg::chan_t out_second;
  tmd_pkg::chan_t out_third;

  modport source (output valid, out_first, out_second, out_third, input ready);
  modport sink   (input valid, out_first, out_second, out_third, output ready);
endinterface

>>> hdl/tmd_cfg_if.sv
// ----------------------------------------------------------------------------
// tmd_cfg_if
// frame width write channel
// ----------------------------------------------------------------------------
interface tmd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tmd_pkg::CFG_W-1:0]  frame_width;

  modport source (output valid, frame_width, input ready);
  modport sink   (input valid, frame_width, output ready);
endinterface

>>> hdl/tmd_lane.sv
// ----------------------------------------------------------------------------
// tmd_lane
// trimmed mean of four bytes: drop min and max, halve the middle pair
// ----------------------------------------------------------------------------
module tmd_lane (
  input  tmd_pkg::chan_t a,
  input  tmd_pkg::chan_t b,
  input  tmd_pkg::chan_t c,
  input  tmd_pkg::chan_t d,
  output tmd_pkg::chan_t mean
);

  localparam int SW = tmd_pkg::CHAN_W + 2;

  tmd_pkg::chan_t lo_ab, hi_ab, lo_cd, hi_cd, lo, hi;
  logic [SW-1:0]  sum, mid;

  always_comb begin
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    lo_cd = (c < d) ? c : d;
    hi_cd = (c < d) ? d : c;
    lo    = (lo_ab < lo_cd) ? lo_ab : lo_cd;
    hi    = (hi_ab > hi_cd) ? hi_ab : hi_cd;
    sum   = SW'(a) + SW'(b) + SW'(c) + SW'(d);
    mid   = sum - SW'(lo) - SW'(hi);
    mean  = mid[tmd_pkg::CHAN_W:1];
  end

endmodule

>>> hdl/tmd_front.sv
// ----------------------------------------------------------------------------
// tmd_front
// raster position, held pixel and pair line store; gathers 2x2 blocks
// ----------------------------------------------------------------------------
module tmd_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      accept,
  input  logic                      start_of_frame,
  input  tmd_pkg::pix_t             pix,
  input  logic [tmd_pkg::CFG_W-1:0] frame_width,
  output tmd_pkg::blk_t             blk
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WREQ = $clog2(MAX_WIDTH + 1);
  localparam int WW   = (WREQ > tmd_pkg::CFG_W) ? WREQ : tmd_pkg::CFG_W;
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int AW   = $clog2(PAIR_DEPTH);

  logic [CW-1:0]         col_r, col;
  logic                  odd_r, odd;
  tmd_pkg::pix_t         held_r;
  logic [WW-1:0]         fw_x, max_x, eff_w, col_x;
  logic                  in_range, last, wr, rd;
  logic [AW-1:0]         idx;
  logic [2*tmd_pkg::PIX_W-1:0] store [PAIR_DEPTH];
  logic [2*tmd_pkg::PIX_W-1:0] rdata_r;
  logic                  s1_valid_r;
  tmd_pkg::pix_t         s1_held_r, s1_pix_r;

  always_comb begin
    fw_x     = WW'(frame_width);
    max_x    = WW'(MAX_WIDTH);
    if (fw_x > max_x) begin
      eff_w = max_x;
    end else if (fw_x == '0) begin
      eff_w = WW'(1);
    end else begin
      eff_w = fw_x;
    end
    col      = start_of_frame ? '0 : col_r;
    odd      = start_of_frame ? 1'b0 : odd_r;
    col_x    = WW'(col);
    in_range = col_x < eff_w;
    last     = (col_x + WW'(1)) >= eff_w;
    wr       = accept && col[0] && in_range && !odd;
    rd       = accept && col[0] && in_range && odd;
    idx      = AW'(col >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      odd_r  <= 1'b0;
      held_r <= '0;
    end else if (accept) begin
      if (last) begin
        col_r <= '0;
        odd_r <= !odd;
      end else begin
        col_r <= col + CW'(1);
        odd_r <= odd;
      end
      if (!col[0]) begin
        held_r <= pix;
      end
    end
  end

  // line store, even-column pixel in the low half
  always_ff @(posedge clk) begin
    if (wr) begin
      store[idx] <= {pix, held_r};
    end
    if (rd) begin
      rdata_r <= store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      s1_held_r <= held_r;
      s1_pix_r  <= pix;
    end
  end

  always_comb begin
    blk.valid      = s1_valid_r;
    blk.above_even = rdata_r[tmd_pkg::PIX_W-1:0];
    blk.above_odd  = rdata_r[2*tmd_pkg::PIX_W-1:tmd_pkg::PIX_W];
    blk.held       = s1_held_r;
    blk.pix        = s1_pix_r;
  end

endmodule

>>> hdl/trimmed_mean_2x2_downsample.sv
// ----------------------------------------------------------------------------
// trimmed_mean_2x2_downsample
// halves a raw three-byte pixel stream in both directions by a 2x2
// trimmed mean per channel, channel order reversed on output
// ----------------------------------------------------------------------------
// channel  dir  payload                               when taken
// in_ch    in   start_of_frame, chan0..chan2          valid & ready
// out_ch   out  out_first, out_second, out_third      valid & ready
// cfg_ch   in   frame_width                           valid & ready (ready high)
//
// one item per cycle unless stalled; a result for the odd-column item of an
// odd row goes through the line store read, then the lane/merge register
// stalls only when the output register is full and out_ch.ready is low
// reset clears position, held pixel and valids; width resets to 640
// the line store is not cleared and needs no start-up pass
// ----------------------------------------------------------------------------
module trimmed_mean_2x2_downsample #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  tmd_pix_if.sink  in_ch,
  tmd_res_if.source out_ch,
  tmd_cfg_if.sink  cfg_ch
);

  logic [tmd_pkg::CFG_W-1:0] frame_width_r;
  logic                      en, accept;
  tmd_pkg::blk_t             blk;
  tmd_pkg::chan_t            mean [tmd_pkg::NUM_CHAN];
  logic                      out_valid_r;
  tmd_pkg::chan_t            out_first_r, out_second_r, out_third_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= tmd_pkg::WIDTH_RST;
    end else if (cfg_ch.valid) begin
      frame_width_r <= cfg_ch.frame_width;
    end
  end

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign accept      = in_ch.valid && en;

  tmd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .accept         (accept),
    .start_of_frame (in_ch.start_of_frame),
    .pix            ({in_ch.chan2, in_ch.chan1, in_ch.chan0}),
    .frame_width    (frame_width_r),
    .blk            (blk)
  );

  for (genvar k = 0; k < tmd_pkg::NUM_CHAN; k++) begin : g_lane
    tmd_lane u_lane (
      .a    (blk.above_even[k*tmd_pkg::CHAN_W +: tmd_pkg::CHAN_W]),
      .b    (blk.above_odd[k*tmd_pkg::CHAN_W +: tmd_pkg::CHAN_W]),
      .c    (blk.held[k*tmd_pkg::CHAN_W +: tmd_pkg::CHAN_W]),
      .d    (blk.pix[k*tmd_pkg::CHAN_W +: tmd_pkg::CHAN_W]),
      .mean (mean[k])
    );
  end

  // merge: lanes into the output register, channel order reversed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= blk.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && blk.valid) begin
      out_first_r  <= mean[2];
      out_second_r <= mean[1];
      out_third_r  <= mean[0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_first  = out_first_r;
  assign out_ch.out_second = out_second_r;
  assign out_ch.out_third  = out_third_r;

endmodule

>>> hdl/tmd_check.sv
// ----------------------------------------------------------------------------
// tmd_check
// port-level checks of the downsampler, bound to the top level
// ----------------------------------------------------------------------------
`include "trimmed_mean_2x2_downsample_defines.svh"

module tmd_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);

  // a result held back must stay offered
  `TMD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a new result needs an item taken earlier
  `TMD_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without item")

  // input backs off only behind a stalled result
  `TMD_ASSERT_IMP(a_in_ready, clk, rst_n, !in_ready, out_valid && !out_ready, "input blocked without output stall")

  // width register always writable
  `TMD_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "config port not ready")

endmodule

bind trimmed_mean_2x2_downsample tmd_check u_tmd_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg_ch.ready)
);

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 2x2 trimmed-mean downsampler: pixel rows are
// pushed through the input channel and a line-pair model of the block
// predicts each downsampled item, compared field by field on the output
// channel under several frame widths and handshake idle/stall patterns
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LINE_MAX   = 2048;
  localparam int PAIR_SLOTS = LINE_MAX / 2;

  typedef struct packed {
    tmd_pkg::chan_t first;
    tmd_pkg::chan_t second;
    tmd_pkg::chan_t third;
  } half_pix_t;

  logic clk;
  logic rst_n;

  tmd_pix_if pix_if ();
  tmd_res_if res_if ();
  tmd_cfg_if cfg_if ();

  trimmed_mean_2x2_downsample #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (pix_if),
    .out_ch(res_if),
    .cfg_ch(cfg_if)
  );

  // downsampler model state
  logic [tmd_pkg::CFG_W-1:0]   width_m;
  logic [2*tmd_pkg::PIX_W-1:0] pair_store_m [PAIR_SLOTS];
  tmd_pkg::pix_t               held_m;
  int                          col_m;
  logic                        odd_row_m;

  half_pix_t expected_means[$];
  int        pixels_sent;
  int        means_checked;
  int        mismatches;
  int        widths_written;
  int        sender_idle_pct;
  int        sink_stall_pct;
  logic      frame_restart_due;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int eff_width(logic [tmd_pkg::CFG_W-1:0] w);
    if (w > LINE_MAX) return LINE_MAX;
    if (w == 0) return 1;
    return int'(w);
  endfunction

  function automatic tmd_pkg::chan_t trimmed_mean(tmd_pkg::chan_t a, tmd_pkg::chan_t b,
                                                  tmd_pkg::chan_t c, tmd_pkg::chan_t d);
    tmd_pkg::chan_t lo;
    tmd_pkg::chan_t hi;
    logic [9:0]     total;
    lo = a;
    hi = a;
    if (b < lo) lo = b;
    if (b > hi) hi = b;
    if (c < lo) lo = c;
    if (c > hi) hi = c;
    if (d < lo) lo = d;
    if (d > hi) hi = d;
    total = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d} - {2'b0, lo} - {2'b0, hi};
    return total[8:1];
  endfunction

  function automatic void downsample_step(logic sof, tmd_pkg::pix_t px);
    int                          w;
    int                          slot;
    logic [2*tmd_pkg::PIX_W-1:0] above;
    half_pix_t                   m;
    w = eff_width(width_m);
    if (sof) begin
      col_m     = 0;
      odd_row_m = 1'b0;
    end
    if (col_m % 2 == 0) begin
      held_m = px;
    end else if (col_m < w) begin
      slot = (col_m / 2) % PAIR_SLOTS;
      if (!odd_row_m) begin
        pair_store_m[slot] = {px, held_m};
      end else begin
        above    = pair_store_m[slot];
        m.first  = trimmed_mean(above[23:16], above[47:40], held_m[23:16], px[23:16]);
        m.second = trimmed_mean(above[15:8], above[39:32], held_m[15:8], px[15:8]);
        m.third  = trimmed_mean(above[7:0], above[31:24], held_m[7:0], px[7:0]);
        expected_means.push_back(m);
      end
    end
    if (col_m + 1 >= w) begin
      col_m     = 0;
      odd_row_m = ~odd_row_m;
    end else begin
      col_m++;
    end
  endfunction

  function automatic tmd_pkg::chan_t random_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return tmd_pkg::chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic tmd_pkg::pix_t random_pixel();
    return {random_chan(), random_chan(), random_chan()};
  endfunction

  function automatic logic [tmd_pkg::CFG_W-1:0] random_width();
    case ($urandom_range(9))
      0: return tmd_pkg::CFG_W'($urandom_range(0, 1));
      1: return tmd_pkg::CFG_W'(2 * $urandom_range(1, 7) + 1);
      default: return tmd_pkg::CFG_W'(2 * $urandom_range(1, 8));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    half_pix_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_means.size() == 0) begin
        mismatches++;
        $error("unexpected item: out_first %0d out_second %0d out_third %0d",
               res_if.out_first, res_if.out_second, res_if.out_third);
      end else begin
        want = expected_means.pop_front();
        means_checked++;
        if (res_if.out_first !== want.first) begin
          mismatches++;
          $error("out_first: expected %0d, got %0d", want.first, res_if.out_first);
        end
        if (res_if.out_second !== want.second) begin
          mismatches++;
          $error("out_second: expected %0d, got %0d", want.second, res_if.out_second);
        end
        if (res_if.out_third !== want.third) begin
          mismatches++;
          $error("out_third: expected %0d, got %0d", want.third, res_if.out_third);
        end
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_pixel(logic sof, tmd_pkg::pix_t px);
    logic sof_eff;
    sof_eff           = sof | frame_restart_due;
    frame_restart_due = 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid          <= 1'b1;
    pix_if.start_of_frame <= sof_eff;
    pix_if.chan0          <= px[7:0];
    pix_if.chan1          <= px[15:8];
    pix_if.chan2          <= px[23:16];
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    downsample_step(sof_eff, px);
    pixels_sent++;
  endtask

  task automatic send_run(int n, logic sof_first);
    for (int i = 0; i < n; i++) send_pixel(sof_first && i == 0, random_pixel());
  endtask

  task automatic send_block(tmd_pkg::pix_t a, tmd_pkg::pix_t b, tmd_pkg::pix_t c,
                            tmd_pkg::pix_t d, logic sof);
    send_pixel(sof, a);
    send_pixel(1'b0, b);
    send_pixel(1'b0, c);
    send_pixel(1'b0, d);
  endtask

  // stop sending and let every pending item drain out
  task automatic settle_block();
    pix_if.valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(logic [tmd_pkg::CFG_W-1:0] w);
    settle_block();
    cfg_if.valid       <= 1'b1;
    cfg_if.frame_width <= w;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    // a wider row must start a fresh frame so no unwritten pair is read
    if (eff_width(w) > eff_width(width_m)) frame_restart_due = 1'b1;
    width_m = w;
    widths_written++;
  endtask

  // one full even row at the reset width, then the start of the odd row
  task automatic test_reset_width();
    send_run(int'(tmd_pkg::WIDTH_RST) + 4, 1'b1);
  endtask

  task automatic test_block_extremes();
    write_width(tmd_pkg::CFG_W'(2));
    send_block(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    send_block(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_block(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0);
    send_block(24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_block(24'h0110FE, 24'h0220FD, 24'h0440FC, 24'h0780FB, 1'b0);
    send_block(24'hFF00FF, 24'h00FF00, 24'hFF00FF, 24'h00FF01, 1'b0);
  endtask

  // last column has no partner, last row has no partner
  task automatic test_odd_width();
    write_width(tmd_pkg::CFG_W'(5));
    send_run(3 * 5, 1'b1);
  endtask

  task automatic test_frame_restart();
    write_width(tmd_pkg::CFG_W'(6));
    send_run(6 + 3, 1'b1);
    send_run(2 * 6, 1'b1);
    send_run(6, 1'b0);
  endtask

  task automatic test_degenerate_width();
    write_width(tmd_pkg::CFG_W'(0));
    send_run(8, 1'b0);
    write_width(tmd_pkg::CFG_W'(1));
    send_run(8, 1'b1);
  endtask

  task automatic test_mid_frame_shrink();
    write_width(tmd_pkg::CFG_W'(8));
    send_run(8 + 5, 1'b1);
    write_width(tmd_pkg::CFG_W'(4));
    send_run(9, 1'b0);
  endtask

  task automatic test_wide_rows();
    write_width(tmd_pkg::CFG_W'(LINE_MAX));
    send_run(24, 1'b1);
    write_width('1);
    send_run(24, 1'b1);
  endtask

  task automatic test_random_stream(int total);
    int goal;
    int rows;
    int run;
    int cut;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 65;
          sink_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 65;
        end
        default: begin
          sender_idle_pct = 7;
          sink_stall_pct  = 7;
        end
      endcase
      write_width(random_width());
      goal = pixels_sent + total / 4;
      while (pixels_sent < goal) begin
        if ($urandom_range(3) == 0) write_width(random_width());
        rows = $urandom_range(1, 5);
        run  = rows * eff_width(width_m);
        cut  = ($urandom_range(9) == 0) ? $urandom_range(1, run) : run;
        send_run(cut, $urandom_range(4) != 0);
        if ($urandom_range(7) == 0) settle_block();
      end
      // sender holds off until the block has emptied
      settle_block();
    end
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
  endtask

  initial begin
    rst_n                 = 1'b0;
    pix_if.valid          = 1'b0;
    pix_if.start_of_frame = 1'b0;
    pix_if.chan0          = '0;
    pix_if.chan1          = '0;
    pix_if.chan2          = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.frame_width    = tmd_pkg::WIDTH_RST;
    sender_idle_pct       = 0;
    sink_stall_pct        = 0;
    pixels_sent           = 0;
    means_checked         = 0;
    mismatches            = 0;
    widths_written        = 0;
    frame_restart_due     = 1'b0;
    width_m               = tmd_pkg::WIDTH_RST;
    held_m                = '0;
    col_m                 = 0;
    odd_row_m             = 1'b0;
    for (int i = 0; i < PAIR_SLOTS; i++) pair_store_m[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_width();
    test_block_extremes();
    test_odd_width();
    test_frame_restart();
    test_degenerate_width();
    test_mid_frame_shrink();
    test_wide_rows();
    test_random_stream(440);

    settle_block();
    repeat (6) @(posedge clk);

    $display("run covered %0d pixels and %0d downsampled items over %0d width settings,",
             pixels_sent, means_checked, widths_written);
    $display("with idle, stall and back-to-back handshake phases; %0d field errors",
             mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tmd_pkg.sv
hdl/tmd_pix_if.sv
hdl/tmd_res_if.sv
hdl/tmd_cfg_if.sv
hdl/tmd_lane.sv
hdl/tmd_front.sv
hdl/trimmed_mean_2x2_downsample.sv
hdl/tmd_check.sv
sim/tb_top.sv
